// ----- design/ipv6v_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6v_pkg
// Shared types and constants of the IPv6 address text checker: the token that
// the character classifier hands to the parser, and the limits of the syntax.
// ----------------------------------------------------------------------------
package ipv6v_pkg;

   // token queue
   localparam int QUEUE_DEPTH = 2;

   // syntax limits
   localparam logic [2:0] MAX_GROUP_DIGITS = 3'd4;
   localparam logic [3:0] MAX_GROUPS_DC    = 4'd7;
   localparam logic [3:0] FULL_GROUPS      = 4'd8;
   localparam logic [3:0] GROUPS_SAT       = 4'd15;
   localparam logic [8:0] OCTET_MAX        = 9'd255;
   localparam logic [8:0] OCTET_SAT        = 9'd256;
   localparam logic [2:0] TAIL_DOTS        = 3'd3;

   // ascii codes
   localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI = 8'h46;
   localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
   localparam logic [7:0] CHAR_LOWER_HI = 8'h66;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;

   // classified character
   typedef struct packed {
      logic       is_end;
      logic       is_dec;
      logic       is_hex;
      logic       is_colon;
      logic       is_dot;
      logic [3:0] digit;
   } token_type;

endpackage : ipv6v_pkg
`default_nettype wire

// ----- design/ipv6v_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6v_classify
// Front end: sorts one incoming character (or the end marker) into the
// classes the parser works on and extracts the decimal digit value.
// ----------------------------------------------------------------------------
module ipv6v_classify
   import ipv6v_pkg::*;
(
   input  wire logic [7:0] ch,
   input  wire logic       end_marker,
   output token_type       token
);

   logic is_dec;
   logic is_letter;

   assign is_dec    = (ch >= CHAR_DIGIT_LO) && (ch <= CHAR_DIGIT_HI);
   assign is_letter = ((ch >= CHAR_UPPER_LO) && (ch <= CHAR_UPPER_HI)) ||
                      ((ch >= CHAR_LOWER_LO) && (ch <= CHAR_LOWER_HI));

   always_comb begin
      token.is_end   = end_marker;
      token.is_dec   = is_dec;
      token.is_hex   = is_dec || is_letter;
      token.is_colon = (ch == CHAR_COLON);
      token.is_dot   = (ch == CHAR_DOT);
      token.digit    = ch[3:0];
   end

endmodule : ipv6v_classify
`default_nettype wire

// ----- design/ipv6v_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6v_queue
// Small token queue between classifier and parser; push and pop may happen
// in the same cycle.
// ----------------------------------------------------------------------------
module ipv6v_queue
   import ipv6v_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire token_type in_token,
   output logic           out_valid,
   input  wire logic      out_ready,
   output token_type      out_token
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   token_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != CntW'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_token = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_token;
      end
   end

endmodule : ipv6v_queue
`default_nettype wire

// ----- design/ipv6v_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6v_parse
// Back end: walks the address syntax one token per cycle unless an end marker
// waits on rsp_ready; it then loads the verdict register and clears state.
// ----------------------------------------------------------------------------
module ipv6v_parse
   import ipv6v_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      tok_valid,
   output logic           tok_ready,
   input  wire token_type tok,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output logic           rsp_valid_res,
   output logic [3:0]     rsp_group_count
);

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD_COLON,
      PH_AFTER_DOUBLE,
      PH_HEX_GROUP,
      PH_DEC_GROUP,
      PH_AFTER_COLON
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] groups_ff, groups_in;
   logic [2:0] digits_ff, digits_in;
   logic       dc_seen_ff, dc_seen_in;
   logic       in_tail_ff, in_tail_in;
   logic [8:0] octet_ff, octet_in;
   logic       has_digit_ff, has_digit_in;
   logic [2:0] dots_ff, dots_in;
   logic       failed_ff, failed_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_valid_res_ff, rsp_valid_res_in;
   logic [3:0] rsp_group_count_ff, rsp_group_count_in;

   logic       pop;
   logic       form_ok;
   logic       ok;
   logic [3:0] groups_fin;
   logic [3:0] groups_clip;

   function automatic logic [8:0] octet_push(logic [8:0] v, logic [3:0] d);
      logic [11:0] n;
      n = ({3'b000, v} << 3) + ({3'b000, v} << 1) + {8'h00, d};
      return (n > {3'b000, OCTET_MAX}) ? OCTET_SAT : n[8:0];
   endfunction

   function automatic logic [3:0] group_inc(logic [3:0] g);
      return (g == GROUPS_SAT) ? g : g + 4'd1;
   endfunction

   // a pending result only blocks the end marker
   assign tok_ready = !tok.is_end || !rsp_valid_ff || rsp_ready;
   assign pop       = tok_valid && tok_ready;

   // verdict on the current state
   always_comb begin
      groups_fin = groups_ff;
      form_ok    = 1'b0;
      if (in_tail_ff) begin
         form_ok    = (dots_ff == TAIL_DOTS) && has_digit_ff && (octet_ff <= OCTET_MAX);
         groups_fin = group_inc(group_inc(groups_ff));
      end else if (phase_ff == PH_HEX_GROUP || phase_ff == PH_DEC_GROUP) begin
         form_ok    = 1'b1;
         groups_fin = group_inc(groups_ff);
      end else begin
         form_ok    = (phase_ff == PH_AFTER_DOUBLE);
      end
      ok = !failed_ff && form_ok &&
           (dc_seen_ff ? (groups_fin <= MAX_GROUPS_DC) : (groups_fin == FULL_GROUPS));
      groups_clip = (groups_fin > FULL_GROUPS) ? FULL_GROUPS : groups_fin;
   end

   always_comb begin
      phase_in           = phase_ff;
      groups_in          = groups_ff;
      digits_in          = digits_ff;
      dc_seen_in         = dc_seen_ff;
      in_tail_in         = in_tail_ff;
      octet_in           = octet_ff;
      has_digit_in       = has_digit_ff;
      dots_in            = dots_ff;
      failed_in          = failed_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_valid_res_in   = rsp_valid_res_ff;
      rsp_group_count_in = rsp_group_count_ff;

      if (pop && tok.is_end) begin
         rsp_valid_in       = 1'b1;
         rsp_valid_res_in   = ok;
         rsp_group_count_in = ok ? groups_clip : 4'd0;
         phase_in           = PH_START;
         groups_in          = '0;
         digits_in          = '0;
         dc_seen_in         = 1'b0;
         in_tail_in         = 1'b0;
         octet_in           = '0;
         has_digit_in       = 1'b0;
         dots_in            = '0;
         failed_in          = 1'b0;
      end else if (pop && !failed_ff) begin
         if (in_tail_ff) begin
            if (tok.is_dec) begin
               octet_in     = octet_push(octet_ff, tok.digit);
               has_digit_in = 1'b1;
            end else if (tok.is_dot && has_digit_ff && (octet_ff <= OCTET_MAX) &&
                         (dots_ff < TAIL_DOTS)) begin
               dots_in      = dots_ff + 3'd1;
               octet_in     = '0;
               has_digit_in = 1'b0;
            end else begin
               failed_in = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_START, PH_AFTER_DOUBLE, PH_AFTER_COLON: begin
                  if (tok.is_colon && phase_ff != PH_AFTER_DOUBLE) begin
                     if (phase_ff == PH_START) begin
                        phase_in = PH_LEAD_COLON;
                     end else if (dc_seen_ff) begin
                        failed_in = 1'b1;
                     end else begin
                        dc_seen_in = 1'b1;
                        phase_in   = PH_AFTER_DOUBLE;
                     end
                  end else if (tok.is_hex) begin
                     digits_in = 3'd1;
                     if (tok.is_dec) begin
                        octet_in = {5'b00000, tok.digit};
                        phase_in = PH_DEC_GROUP;
                     end else begin
                        octet_in = '0;
                        phase_in = PH_HEX_GROUP;
                     end
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               PH_LEAD_COLON: begin
                  if (tok.is_colon && !dc_seen_ff) begin
                     dc_seen_in = 1'b1;
                     phase_in   = PH_AFTER_DOUBLE;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               PH_HEX_GROUP, PH_DEC_GROUP: begin
                  if (tok.is_colon) begin
                     groups_in = group_inc(groups_ff);
                     digits_in = '0;
                     phase_in  = PH_AFTER_COLON;
                  end else if (tok.is_dot && phase_ff == PH_DEC_GROUP) begin
                     if (octet_ff > OCTET_MAX) begin
                        failed_in = 1'b1;
                     end else begin
                        in_tail_in   = 1'b1;
                        dots_in      = 3'd1;
                        octet_in     = '0;
                        has_digit_in = 1'b0;
                     end
                  end else if (tok.is_hex) begin
                     if (digits_ff >= MAX_GROUP_DIGITS) begin
                        failed_in = 1'b1;
                     end else begin
                        digits_in = digits_ff + 3'd1;
                        if (phase_ff == PH_DEC_GROUP && tok.is_dec) begin
                           octet_in = octet_push(octet_ff, tok.digit);
                        end else begin
                           phase_in = PH_HEX_GROUP;
                        end
                     end
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               default: begin
                  failed_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         groups_ff    <= '0;
         digits_ff    <= '0;
         dc_seen_ff   <= 1'b0;
         in_tail_ff   <= 1'b0;
         octet_ff     <= '0;
         has_digit_ff <= 1'b0;
         dots_ff      <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         groups_ff    <= groups_in;
         digits_ff    <= digits_in;
         dc_seen_ff   <= dc_seen_in;
         in_tail_ff   <= in_tail_in;
         octet_ff     <= octet_in;
         has_digit_ff <= has_digit_in;
         dots_ff      <= dots_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_valid_res_ff   <= rsp_valid_res_in;
      rsp_group_count_ff <= rsp_group_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = rsp_valid_res_ff;
   assign rsp_group_count = rsp_group_count_ff;

   // state cleared after every verdict
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (pop && tok.is_end) |=> (groups_ff == '0 && !failed_ff && !dc_seen_ff && !in_tail_ff))
      else $error("parser state not cleared after end marker");

   // a rejected address reports no groups
   a_invalid_no_groups: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_valid_res_ff) |-> (rsp_group_count_ff == 4'd0))
      else $error("group count on rejected address");

   // dotted tail bookkeeping only inside the tail
   a_dots_in_tail: assert property (@(posedge clock) disable iff (reset)
      (dots_ff != '0) |-> in_tail_ff)
      else $error("dots counted outside ipv4 tail");

   a_group_digits: assert property (@(posedge clock) disable iff (reset)
      digits_ff <= MAX_GROUP_DIGITS)
      else $error("group digit count overflow");

   // end marker never overwrites a result not yet transferred
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_valid_res_ff) && rsp_valid_ff)
      else $error("pending result overwritten");

endmodule : ipv6v_parse
`default_nettype wire

// ----- design/ipv6_text_address_validator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_text_address_validator_top
// Checks the text of an IPv6 address fed one character per transfer and
// gives a verdict and group count for each end marker.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_ch[7:0], req_end_marker
//   rsp      out        rsp_valid/rsp_ready  rsp_valid_res, rsp_group_count[3:0]
//
// one character per cycle sustained while no end marker waits on rsp_ready;
// the end marker is queued, then the parser loads its verdict into the result register
// req_ready falls only when the token queue is full
// the parser holds an end marker only while a verdict waits on rsp_ready
// synchronous reset clears all parse state at once, no clearing pass
// ----------------------------------------------------------------------------
module ipv6_text_address_validator_top
   import ipv6v_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_end_marker,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_valid_res,
   output logic [3:0]      rsp_group_count
);

   token_type in_token;
   token_type q_token;
   logic      q_valid;
   logic      q_ready;

   ipv6v_classify u_classify (
      .ch         (req_ch),
      .end_marker (req_end_marker),
      .token      (in_token)
   );

   ipv6v_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_token  (in_token),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_token (q_token)
   );

   ipv6v_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (q_valid),
      .tok_ready       (q_ready),
      .tok             (q_token),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_group_count (rsp_group_count)
   );

endmodule : ipv6_text_address_validator_top
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPv6 address text checker. Addresses are fed
// one character per transfer and closed by an end marker; a table of directed
// addresses comes first, then random addresses, mostly well formed with
// random content, some mutated, some pure noise. A parser model in the bench
// predicts the verdicts not typed in the table, and the response port is
// compared field by field under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench
   import ipv6v_pkg::*;
();

   localparam int CYCLE_LIMIT    = 200000;
   localparam int CHARS_PER_MIX  = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int DIR_ROWS       = 24;

   typedef enum logic [2:0] {
      PHASE_START       = 3'd0,
      PHASE_LEAD_COLON  = 3'd1,
      PHASE_AFTER_DOUBLE = 3'd2,
      PHASE_HEX_GROUP   = 3'd3,
      PHASE_DEC_GROUP   = 3'd4,
      PHASE_AFTER_COLON = 3'd5
   } parse_phase_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch         = 8'd0;
   logic       req_end_marker = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic       rsp_valid_res;
   logic [3:0] rsp_group_count;

   ipv6_text_address_validator_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_end_marker (req_end_marker),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_group_count(rsp_group_count)
   );

   always #5 clock = ~clock;

   // parser model state
   parse_phase_type phase_q;
   logic [3:0]   groups_q;
   logic [2:0]   digits_q;
   logic         double_colon_q;
   logic         in_tail_q;
   logic [8:0]   octet_q;
   logic         octet_dig_q;
   logic [2:0]   dots_q;
   logic         failed_q;

   // pending verdicts as {valid_res, group_count}
   logic [4:0] verdict_q[$];
   logic [7:0] addr_text[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;
   int chars_sent    = 0;
   int cycles        = 0;

   string      dir_text  [DIR_ROWS];
   bit         dir_typed [DIR_ROWS];
   logic [4:0] dir_result[DIR_ROWS];

   function automatic bit is_dec_char(logic [7:0] c);
      return c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI;
   endfunction

   function automatic bit is_hex_char(logic [7:0] c);
      return is_dec_char(c) || (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
             (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI);
   endfunction

   function automatic logic [8:0] next_octet(logic [8:0] v, logic [7:0] c);
      int n;
      n = int'(v) * 10 + int'(c) - int'(CHAR_DIGIT_LO);
      return (n > int'(OCTET_MAX)) ? OCTET_SAT : n[8:0];
   endfunction

   function automatic logic [3:0] bump_groups(logic [3:0] g);
      return (g < GROUPS_SAT) ? g + 4'd1 : g;
   endfunction

   task automatic add_char(logic [7:0] c);
      addr_text.insert(addr_text.size(), c);
   endtask

   task automatic add_verdict(logic [4:0] v);
      verdict_q.insert(verdict_q.size(), v);
   endtask

   task automatic clear_parser();
      phase_q        = PHASE_START;
      groups_q       = 4'd0;
      digits_q       = 3'd0;
      double_colon_q = 1'b0;
      in_tail_q      = 1'b0;
      octet_q        = 9'd0;
      octet_dig_q    = 1'b0;
      dots_q         = 3'd0;
      failed_q       = 1'b0;
   endtask

   task automatic open_group(logic [7:0] c);
      digits_q = 3'd1;
      if (is_dec_char(c)) begin
         octet_q = {1'b0, c - CHAR_DIGIT_LO};
         phase_q = PHASE_DEC_GROUP;
      end else begin
         octet_q = 9'd0;
         phase_q = PHASE_HEX_GROUP;
      end
   endtask

   task automatic advance_parser(logic [7:0] c);
      if (in_tail_q) begin
         if (is_dec_char(c)) begin
            octet_q     = next_octet(octet_q, c);
            octet_dig_q = 1'b1;
         end else if (c == CHAR_DOT && octet_dig_q && octet_q <= OCTET_MAX &&
                      dots_q < TAIL_DOTS) begin
            dots_q      = dots_q + 3'd1;
            octet_q     = 9'd0;
            octet_dig_q = 1'b0;
         end else begin
            failed_q = 1'b1;
         end
         return;
      end
      case (phase_q)
         PHASE_START: begin
            if (c == CHAR_COLON) phase_q = PHASE_LEAD_COLON;
            else if (is_hex_char(c)) open_group(c);
            else failed_q = 1'b1;
         end
         PHASE_LEAD_COLON: begin
            if (c == CHAR_COLON && !double_colon_q) begin
               double_colon_q = 1'b1;
               phase_q        = PHASE_AFTER_DOUBLE;
            end else begin
               failed_q = 1'b1;
            end
         end
         PHASE_AFTER_DOUBLE: begin
            if (is_hex_char(c)) open_group(c);
            else failed_q = 1'b1;
         end
         PHASE_AFTER_COLON: begin
            if (c == CHAR_COLON) begin
               if (double_colon_q) begin
                  failed_q = 1'b1;
               end else begin
                  double_colon_q = 1'b1;
                  phase_q        = PHASE_AFTER_DOUBLE;
               end
            end else if (is_hex_char(c)) begin
               open_group(c);
            end else begin
               failed_q = 1'b1;
            end
         end
         PHASE_HEX_GROUP, PHASE_DEC_GROUP: begin
            if (c == CHAR_COLON) begin
               groups_q = bump_groups(groups_q);
               digits_q = 3'd0;
               phase_q  = PHASE_AFTER_COLON;
            end else if (c == CHAR_DOT && phase_q == PHASE_DEC_GROUP) begin
               if (octet_q > OCTET_MAX) begin
                  failed_q = 1'b1;
               end else begin
                  in_tail_q   = 1'b1;
                  dots_q      = 3'd1;
                  octet_q     = 9'd0;
                  octet_dig_q = 1'b0;
               end
            end else if (is_hex_char(c)) begin
               if (digits_q >= MAX_GROUP_DIGITS) begin
                  failed_q = 1'b1;
               end else begin
                  digits_q = digits_q + 3'd1;
                  if (phase_q == PHASE_DEC_GROUP && is_dec_char(c))
                     octet_q = next_octet(octet_q, c);
                  else
                     phase_q = PHASE_HEX_GROUP;
               end
            end else begin
               failed_q = 1'b1;
            end
         end
         default: failed_q = 1'b1;
      endcase
   endtask

   function automatic logic [4:0] close_address();
      logic       ok;
      logic [3:0] g;
      ok = 1'b1;
      g  = groups_q;
      if (failed_q) begin
         ok = 1'b0;
      end else if (in_tail_q) begin
         if (dots_q != TAIL_DOTS || !octet_dig_q || octet_q > OCTET_MAX) ok = 1'b0;
         else g = bump_groups(bump_groups(g));
      end else if (phase_q == PHASE_HEX_GROUP || phase_q == PHASE_DEC_GROUP) begin
         g = bump_groups(g);
      end else if (phase_q != PHASE_AFTER_DOUBLE) begin
         ok = 1'b0;
      end
      if (ok) ok = double_colon_q ? (g <= MAX_GROUPS_DC) : (g == FULL_GROUPS);
      if (!ok) return 5'd0;
      return {1'b1, (g > FULL_GROUPS) ? FULL_GROUPS : g};
   endfunction

   // one transfer on the request side; called and returns at a rising edge
   task automatic send_item(logic [7:0] c, logic e, bit typed, logic [4:0] want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_ch         <= c;
      req_end_marker <= e;
      do @(posedge clock); while (!req_ready);
      if (e) begin
         if (typed) add_verdict(want);
         else add_verdict(close_address());
         clear_parser();
      end else begin
         chars_sent++;
         if (!failed_q) advance_parser(c);
      end
   endtask

   task automatic send_address(bit typed, logic [4:0] want);
      foreach (addr_text[i]) send_item(addr_text[i], 1'b0, 1'b0, 5'd0);
      send_item(8'($urandom_range(255)), 1'b1, typed, want);
   endtask

   task automatic drain_verdicts();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] hex_char(bit dec_only);
      int k;
      k = dec_only ? $urandom_range(9) : $urandom_range(21);
      if (k < 10) return 8'(CHAR_DIGIT_LO + k);
      if (k < 16) return 8'(CHAR_UPPER_LO + (k - 10));
      return 8'(CHAR_LOWER_LO + (k - 16));
   endfunction

   function automatic logic [7:0] any_char();
      case ($urandom_range(3))
         0:       return CHAR_COLON;
         1:       return CHAR_DOT;
         2:       return hex_char(1'b0);
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic push_group();
      int n;
      bit dec_only;
      n        = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
      dec_only = 1'($urandom_range(1));
      repeat (n) add_char(hex_char(dec_only));
   endtask

   task automatic push_octet();
      int v;
      int k;
      int n;
      int d[5];
      k = $urandom_range(19);
      if (k == 0) return;
      v = (k == 1) ? $urandom_range(256, 9999) : $urandom_range(255);
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 2)) add_char(CHAR_DIGIT_LO);
      end
      n = 0;
      do begin
         d[n] = v % 10;
         v    = v / 10;
         n++;
      end while (v != 0);
      for (int i = n - 1; i >= 0; i--) add_char(8'(CHAR_DIGIT_LO + d[i]));
   endtask

   task automatic push_colons(int n);
      repeat (n) add_char(CHAR_COLON);
   endtask

   task automatic build_random_address();
      bit tail;
      bit use_dc;
      int total;
      int count;
      int gap_at;
      int octets;
      int pos;
      addr_text.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(8)) add_char(any_char());
         return;
      end
      tail   = ($urandom_range(3) == 0);
      use_dc = 1'($urandom_range(1));
      total  = tail ? 6 : 8;
      if (use_dc) count = $urandom_range(total);
      else if ($urandom_range(9) == 0) count = $urandom_range(total - 1, total + 9);
      else count = total;
      gap_at = use_dc ? $urandom_range(count) : -1;
      for (int i = 0; i < count; i++) begin
         if (i == gap_at) push_colons(2);
         else if (i > 0) push_colons(1);
         push_group();
      end
      if (gap_at == count) push_colons(2);
      if (tail) begin
         if (count > 0 && gap_at != count) push_colons(1);
         octets = ($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4;
         for (int i = 0; i < octets; i++) begin
            if (i > 0) add_char(CHAR_DOT);
            push_octet();
         end
      end
      if ($urandom_range(4) == 0 && addr_text.size() > 0) begin
         pos = $urandom_range(addr_text.size() - 1);
         case ($urandom_range(2))
            0:       addr_text[pos] = any_char();
            1:       addr_text.insert(pos, any_char());
            default: addr_text.delete(pos);
         endcase
      end
   endtask

   // response side: check every transfer, stall at random
   always @(posedge clock) begin : rsp_side
      logic [4:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected verdict: valid_res %0d, group_count %0d",
                      rsp_valid_res, rsp_group_count);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_valid_res !== want[4]) begin
                  $error("valid_res mismatch: expected %0d, actual %0d",
                         want[4], rsp_valid_res);
                  mismatches++;
               end
               if (rsp_group_count !== want[3:0]) begin
                  $error("group_count mismatch: expected %0d, actual %0d",
                         want[3:0], rsp_group_count);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int send_mix [4];
      int stall_mix[4];
      int mark;
      send_mix  = '{0, 50, 0, 16};
      stall_mix = '{0, 0, 50, 16};

      dir_text = '{
         "",
         "::",
         "1:2:3:4:5:6:7:8",
         "FFFF:ffff:0:0:0:0:0:0",
         "1::",
         "::1",
         ":1::2",
         "1:2:3:4:5:6:7:",
         "12345::",
         "1::2::3",
         "::ffff:192.168.0.1",
         "1:2:3:4:5:6:255.255.255.255",
         "::1.2.3.256",
         "::1a.2.3.4",
         "::300.1.1.1",
         "::0001.002.3.4",
         "::1..2.3",
         "::1.2.3",
         "::1.2.3.4.5",
         "1:2:3:4:5:6:7:8:9:10:11:12:13:14:15:16:17",
         "g::",
         "::\377",
         "::1:2:3:4:5:6:7",
         "1::2:3:4:5:6:7:8"
      };
      dir_typed  = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0,
                     1, 1, 1, 1, 1, 1, 1, 0};
      dir_result = '{5'h00, 5'h10, 5'h18, 5'h18, 5'h11, 5'h11, 5'h00, 5'h00,
                     5'h00, 5'h00, 5'h13, 5'h18, 5'h00, 5'h00, 5'h00, 5'h00,
                     5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h17, 5'h00};

      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         addr_text.delete();
         for (int i = 0; i < dir_text[r].len(); i++) add_char(dir_text[r][i]);
         send_address(dir_typed[r], dir_result[r]);
      end
      drain_verdicts();

      for (int m = 0; m < 4; m++) begin
         send_idle_pct = send_mix[m];
         rsp_stall_pct = stall_mix[m];
         mark = chars_sent;
         while (chars_sent - mark < CHARS_PER_MIX) begin
            build_random_address();
            send_address(1'b0, 5'd0);
         end
         drain_verdicts();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
